[sv/lz4d_pkg.sv]
// Shared constants and types of the LZ4 block decoder.
`default_nettype none
package lz4d_pkg;

  // Defaults of the top-level parameters.
  localparam int DEF_WINDOW_BITS = 16;
  localparam int DEF_SIZE_BITS   = 24;

  // Fixed field widths.
  localparam int CFG_W   = 25;  // output_size register
  localparam int CNT_W   = 25;  // bytes_consumed field
  localparam int BYTE_W  = 8;
  localparam int OFF_W   = 16;  // match offset as coded in the stream
  localparam int NIB_W   = 4;

  // Register value after reset, smallest legal block size and the
  // constant part of every match length.
  localparam logic [CFG_W-1:0] RESET_SIZE = CFG_W'(65536);
  localparam int               MIN_SIZE   = 4;
  localparam int               MIN_MATCH  = 4;

  // Length nibble and length byte values that call for another byte.
  localparam logic [NIB_W-1:0]  NIB_EXT  = 4'hF;
  localparam logic [BYTE_W-1:0] BYTE_EXT = 8'hFF;

  typedef enum logic [1:0] {
    ST_BYTE = 2'd0,
    ST_DONE = 2'd1,
    ST_ERR  = 2'd2
  } status_t;

  // One result on its way from the parser to the output stage.
  typedef struct packed {
    logic              is_match;  // byte comes from the history memory
    logic              fwd;       // take fwd_byte rather than read data
    logic [BYTE_W-1:0] fwd_byte;
    logic [BYTE_W-1:0] lit_byte;
    status_t           status;
    logic [CNT_W-1:0]  consumed;
  } s1_t;

endpackage
`default_nettype wire

[sv/lz4d_intf.sv]
// Valid/ready channel interfaces of the LZ4 block decoder.
`default_nettype none
interface lz4d_in_if;
  logic                        valid;
  logic                        ready;
  logic                        req_type;
  logic [lz4d_pkg::BYTE_W-1:0] in_byte;

  modport source (output valid, output req_type, output in_byte, input ready);
  modport sink (input valid, input req_type, input in_byte, output ready);
endinterface

interface lz4d_out_if;
  logic                        valid;
  logic                        ready;
  logic [lz4d_pkg::BYTE_W-1:0] out_byte;
  logic [1:0]                  status;
  logic [lz4d_pkg::CNT_W-1:0]  bytes_consumed;

  modport source (output valid, output out_byte, output status,
                  output bytes_consumed, input ready);
  modport sink (input valid, input out_byte, input status,
                input bytes_consumed, output ready);
endinterface

interface lz4d_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [lz4d_pkg::CFG_W-1:0] output_size;

  modport source (output valid, output output_size, input ready);
  modport sink (input valid, input output_size, output ready);
endinterface
`default_nettype wire

[sv/lz4_block_decoder.sv]
// Top level of the LZ4 block decoder.
//
//  channel  dir  payload                               transfer when
//  in_ch    in   req_type, in_byte                     valid && ready
//  out_ch   out  out_byte, status, bytes_consumed      valid && ready
//  cfg_ch   in   output_size                           valid && ready (ready is tied high)
//
// One item is taken per cycle while in_ch.ready is high; its result goes
// through the result stage to the output register. The history memory read
// for a match byte is issued in the accepting cycle; its registered data is
// used as the result leaves the result stage, so the single read port sets
// the rate at one item per cycle. Reset is synchronous and clears all sequence
// state; the history memory is not cleared. When the output register is full
// and not being emptied, the result stage holds one more and in_ch.ready falls.
`default_nettype none
module lz4_block_decoder #(
  parameter int WINDOW_BITS = lz4d_pkg::DEF_WINDOW_BITS,
  parameter int SIZE_BITS   = lz4d_pkg::DEF_SIZE_BITS
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  lz4d_in_if.sink    in_ch,
  lz4d_out_if.source out_ch,
  lz4d_cfg_if.sink   cfg_ch
);

  // Read port of the history, driven by the parser.
  logic                        rd_en;
  logic [WINDOW_BITS-1:0]      rd_addr;
  logic [lz4d_pkg::BYTE_W-1:0] rdata;

  // Write port of the history, driven by the output stage. Every produced
  // byte, literal or copied, is written as it leaves the result stage.
  logic                        wr_en;
  logic [WINDOW_BITS-1:0]      wr_addr;
  logic [lz4d_pkg::BYTE_W-1:0] wr_data;

  // Result stage between parser and output register.
  logic                        s1_valid;
  logic                        s1_go;
  lz4d_pkg::s1_t               s1_q;
  logic [WINDOW_BITS-1:0]      s1_waddr;

  // The parser does all sequence tracking in the accepting cycle. A match
  // with an offset of one reads the byte that the output stage writes in that
  // same cycle, so the parser compares addresses and carries the byte along.
  lz4d_ctrl #(
    .WINDOW_BITS (WINDOW_BITS),
    .SIZE_BITS   (SIZE_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .cfg_ch   (cfg_ch),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .s1_go    (s1_go),
    .s1_valid (s1_valid),
    .s1_q     (s1_q),
    .s1_waddr (s1_waddr)
  );

  lz4d_ram #(
    .WIDTH (lz4d_pkg::BYTE_W),
    .DEPTH (1 << WINDOW_BITS)
  ) u_hist (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  lz4d_emit #(
    .WINDOW_BITS (WINDOW_BITS)
  ) u_emit (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1_valid (s1_valid),
    .s1_q     (s1_q),
    .s1_waddr (s1_waddr),
    .rdata    (rdata),
    .s1_go    (s1_go),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .out_ch   (out_ch)
  );

  // A completion or error result never carries a data byte.
  a_status_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.status != lz4d_pkg::ST_BYTE) |-> out_ch.out_byte == '0)
    else $error("non-data result carries a byte");

  // A read that hits the address being written must take the forwarded byte.
  a_forward: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en && wr_en && (rd_addr == wr_addr) |=> s1_valid && s1_q.fwd)
    else $error("read-during-write collision not forwarded");

  // The input only stalls when both the result stage and output are blocked.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> s1_valid && out_ch.valid && !out_ch.ready)
    else $error("input stalled without a full output path");

endmodule
`default_nettype wire

[sv/lz4d_ram.sv]
// Generic single-clock RAM, one write and one registered read port.
`default_nettype none
module lz4d_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[sv/lz4d_ctrl.sv]
// Stream parser: sequence state, length and size checks, history read issue.
`default_nettype none
module lz4d_ctrl #(
  parameter int WINDOW_BITS = lz4d_pkg::DEF_WINDOW_BITS,
  parameter int SIZE_BITS   = lz4d_pkg::DEF_SIZE_BITS
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  lz4d_in_if.sink                     in_ch,
  lz4d_cfg_if.sink                    cfg_ch,
  // history read port
  output logic                        rd_en,
  output logic [WINDOW_BITS-1:0]      rd_addr,
  // history write of the output stage, for forwarding
  input  wire logic                   wr_en,
  input  wire logic [WINDOW_BITS-1:0] wr_addr,
  input  wire logic [lz4d_pkg::BYTE_W-1:0] wr_data,
  // result handed to the output stage
  input  wire logic                   s1_go,
  output logic                        s1_valid,
  output lz4d_pkg::s1_t               s1_q,
  output logic [WINDOW_BITS-1:0]      s1_waddr
);

  localparam int CW = SIZE_BITS + 1;
  localparam int EW = (CW > lz4d_pkg::CFG_W) ? CW : lz4d_pkg::CFG_W;
  localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};
  localparam logic [16:0] HIST_LEN = 17'(1) << WINDOW_BITS;

  typedef enum logic [3:0] {
    PH_TOKEN, PH_LITEXT, PH_LIT, PH_OFFLO, PH_OFFHI, PH_MATEXT, PH_MATCH,
    PH_DONE, PH_ERR
  } phase_t;

  function automatic logic [CW-1:0] eff_of(input logic [lz4d_pkg::CFG_W-1:0] v);
    logic [EW-1:0] x;
    logic [EW-1:0] top;
    x   = EW'(v);
    top = EW'(1) << SIZE_BITS;
    if (x < EW'(lz4d_pkg::MIN_SIZE)) begin
      x = EW'(lz4d_pkg::MIN_SIZE);
    end else if (x > top) begin
      x = top;
    end
    return CW'(x);
  endfunction

  function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a,
                                            input logic [lz4d_pkg::BYTE_W-1:0] b);
    logic [CW:0] s;
    s = {1'b0, a} + (CW+1)'(b);
    return s[CW] ? CNT_MAX : s[CW-1:0];
  endfunction

  // Next phase once the literal length is known; PH_ERR marks a bad length.
  function automatic phase_t lit_next(input logic [CW-1:0] e, input logic [CW-1:0] p,
                                      input logic [CW-1:0] sz, input logic [CW-1:0] szm4);
    phase_t ph;
    if (e > szm4) begin
      ph = (e != sz || e == p) ? PH_ERR : PH_LIT;
    end else begin
      ph = (e != p) ? PH_LIT : PH_OFFLO;
    end
    return ph;
  endfunction

  function automatic phase_t mat_next(input logic [CW-1:0] e, input logic [CW-1:0] sz);
    return (e > sz) ? PH_ERR : PH_MATCH;
  endfunction

  phase_t                          phase_r, phase_nxt;
  logic [CW-1:0]                   produced_r, produced_nxt;
  logic [CW-1:0]                   consumed_r, consumed_nxt;
  logic [CW-1:0]                   end_r, end_nxt;
  logic [lz4d_pkg::NIB_W-1:0]      nibble_r, nibble_nxt;
  logic [lz4d_pkg::OFF_W-1:0]      offset_r, offset_nxt;
  logic [CW-1:0]                   eff_r, effm4_r;
  logic                            s1_valid_r;
  lz4d_pkg::s1_t                   s1_r, s1_nxt;
  logic [WINDOW_BITS-1:0]          s1_waddr_r;

  logic                            acc;
  logic                            has_res;
  logic [CW-1:0]                   prod_inc;
  logic [CW-1:0]                   ext_end;
  logic [CW-1:0]                   tok_end;
  logic [CW-1:0]                   mat_end;
  logic [lz4d_pkg::OFF_W-1:0]      off_full;
  logic                            off_bad;
  phase_t                          ph_tmp;

  assign in_ch.ready  = !s1_valid_r || s1_go;
  assign cfg_ch.ready = 1'b1;
  assign acc          = in_ch.valid && in_ch.ready;

  assign prod_inc = produced_r + CW'(1);
  assign ext_end  = sat_add(end_r, in_ch.in_byte);
  assign tok_end  = produced_r + CW'(in_ch.in_byte[7:4]);
  assign mat_end  = produced_r + CW'(nibble_r) + CW'(lz4d_pkg::MIN_MATCH);
  assign off_full = {in_ch.in_byte, offset_r[7:0]};
  assign off_bad  = (off_full == '0) || (CW'(off_full) > produced_r) ||
                    (17'(off_full) > HIST_LEN);

  assign rd_addr = produced_r[WINDOW_BITS-1:0] - offset_r[WINDOW_BITS-1:0];

  always_comb begin
    phase_nxt    = phase_r;
    produced_nxt = produced_r;
    consumed_nxt = consumed_r;
    end_nxt      = end_r;
    nibble_nxt   = nibble_r;
    offset_nxt   = offset_r;
    has_res      = 1'b0;
    rd_en        = 1'b0;
    ph_tmp       = PH_ERR;
    s1_nxt.is_match = 1'b0;
    s1_nxt.fwd      = wr_en && (wr_addr == rd_addr);
    s1_nxt.fwd_byte = wr_data;
    s1_nxt.lit_byte = '0;
    s1_nxt.status   = lz4d_pkg::ST_BYTE;
    if (acc) begin
      if (phase_r == PH_DONE) begin
        has_res       = 1'b1;
        s1_nxt.status = lz4d_pkg::ST_DONE;
      end else if (phase_r == PH_ERR) begin
        has_res       = 1'b1;
        s1_nxt.status = lz4d_pkg::ST_ERR;
      end else if (in_ch.req_type) begin
        if (phase_r == PH_MATCH) begin
          rd_en           = 1'b1;
          has_res         = 1'b1;
          s1_nxt.is_match = 1'b1;
          produced_nxt    = prod_inc;
          if (prod_inc == end_r) begin
            phase_nxt = (prod_inc >= eff_r) ? PH_DONE : PH_TOKEN;
          end
        end
      end else if (phase_r != PH_MATCH) begin
        if (consumed_r != CNT_MAX) begin
          consumed_nxt = consumed_r + CW'(1);
        end
        unique case (phase_r)
          PH_TOKEN: begin
            nibble_nxt = in_ch.in_byte[3:0];
            end_nxt    = tok_end;
            if (in_ch.in_byte[7:4] == lz4d_pkg::NIB_EXT) begin
              phase_nxt = PH_LITEXT;
            end else begin
              ph_tmp    = lit_next(tok_end, produced_r, eff_r, effm4_r);
              phase_nxt = ph_tmp;
            end
          end
          PH_LITEXT: begin
            end_nxt = ext_end;
            if (in_ch.in_byte != lz4d_pkg::BYTE_EXT) begin
              ph_tmp    = lit_next(ext_end, produced_r, eff_r, effm4_r);
              phase_nxt = ph_tmp;
            end
          end
          PH_LIT: begin
            has_res         = 1'b1;
            s1_nxt.lit_byte = in_ch.in_byte;
            produced_nxt    = prod_inc;
            if (prod_inc == end_r) begin
              phase_nxt = (prod_inc >= eff_r) ? PH_DONE : PH_OFFLO;
            end
          end
          PH_OFFLO: begin
            offset_nxt = lz4d_pkg::OFF_W'(in_ch.in_byte);
            phase_nxt  = PH_OFFHI;
          end
          PH_OFFHI: begin
            offset_nxt = off_full;
            end_nxt    = mat_end;
            if (off_bad) begin
              phase_nxt = PH_ERR;
            end else if (nibble_r == lz4d_pkg::NIB_EXT) begin
              phase_nxt = PH_MATEXT;
            end else begin
              ph_tmp    = mat_next(mat_end, eff_r);
              phase_nxt = ph_tmp;
            end
          end
          PH_MATEXT: begin
            end_nxt = ext_end;
            if (in_ch.in_byte != lz4d_pkg::BYTE_EXT) begin
              ph_tmp    = mat_next(ext_end, eff_r);
              phase_nxt = ph_tmp;
            end
          end
          default: begin
            phase_nxt = PH_ERR;
          end
        endcase
        if (phase_nxt == PH_ERR) begin
          has_res         = 1'b1;
          s1_nxt.status   = lz4d_pkg::ST_ERR;
          s1_nxt.lit_byte = '0;
        end
      end
    end
    s1_nxt.consumed = lz4d_pkg::CNT_W'(consumed_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_TOKEN;
      produced_r <= '0;
      consumed_r <= '0;
      end_r      <= '0;
      nibble_r   <= '0;
      offset_r   <= '0;
      eff_r      <= eff_of(lz4d_pkg::RESET_SIZE);
      effm4_r    <= eff_of(lz4d_pkg::RESET_SIZE) - CW'(lz4d_pkg::MIN_SIZE);
      s1_valid_r <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      produced_r <= produced_nxt;
      consumed_r <= consumed_nxt;
      end_r      <= end_nxt;
      nibble_r   <= nibble_nxt;
      offset_r   <= offset_nxt;
      if (cfg_ch.valid) begin
        eff_r   <= eff_of(cfg_ch.output_size);
        effm4_r <= eff_of(cfg_ch.output_size) - CW'(lz4d_pkg::MIN_SIZE);
      end
      if (acc && has_res) begin
        s1_valid_r <= 1'b1;
      end else if (s1_go) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc && has_res) begin
      s1_r       <= s1_nxt;
      s1_waddr_r <= produced_r[WINDOW_BITS-1:0];
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_q     = s1_r;
  assign s1_waddr = s1_waddr_r;

endmodule
`default_nettype wire

[sv/lz4d_emit.sv]
// Output stage: picks the result byte, writes it to history, holds the result.
`default_nettype none
module lz4d_emit #(
  parameter int WINDOW_BITS = lz4d_pkg::DEF_WINDOW_BITS
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        s1_valid,
  input  wire lz4d_pkg::s1_t               s1_q,
  input  wire logic [WINDOW_BITS-1:0]      s1_waddr,
  input  wire logic [lz4d_pkg::BYTE_W-1:0] rdata,
  output logic                             s1_go,
  output logic                             wr_en,
  output logic [WINDOW_BITS-1:0]           wr_addr,
  output logic [lz4d_pkg::BYTE_W-1:0]      wr_data,
  lz4d_out_if.source                       out_ch
);

  logic                       out_valid_r;
  logic [lz4d_pkg::BYTE_W-1:0] out_byte_r;
  lz4d_pkg::status_t          status_r;
  logic [lz4d_pkg::CNT_W-1:0] consumed_r;
  logic [lz4d_pkg::BYTE_W-1:0] byte_sel;

  always_comb begin
    if (!s1_q.is_match) begin
      byte_sel = s1_q.lit_byte;
    end else if (s1_q.fwd) begin
      byte_sel = s1_q.fwd_byte;
    end else begin
      byte_sel = rdata;
    end
  end

  assign s1_go   = s1_valid && (!out_valid_r || out_ch.ready);
  assign wr_en   = s1_go && (s1_q.status == lz4d_pkg::ST_BYTE);
  assign wr_addr = s1_waddr;
  assign wr_data = byte_sel;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_byte_r <= byte_sel;
      status_r   <= s1_q.status;
      consumed_r <= s1_q.consumed;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.out_byte       = out_byte_r;
  assign out_ch.status         = status_r;
  assign out_ch.bytes_consumed = consumed_r;

endmodule
`default_nettype wire

[tb/sv/lz4d_tb_pkg.sv]
// Request codes shared by the LZ4 block decoder testbench files.
`timescale 1ns / 1ps
package lz4d_tb_pkg;

  localparam logic REQ_BYTE    = 1'b0;  // in_byte carries a compressed byte
  localparam logic REQ_ADVANCE = 1'b1;  // produce one pending match byte

endpackage

[tb/sv/lz4_block_decoder_checker.sv]
// Decoder prediction and result comparison for the LZ4 block decoder testbench.
`timescale 1ns / 1ps
module lz4_block_decoder_checker (
  input  wire logic clk,
  input  wire logic rst_n,
  lz4d_in_if        in_ch,
  lz4d_out_if       out_ch,
  lz4d_cfg_if       cfg_ch,
  output int        fail_count,
  output int        pending
);
  import lz4d_pkg::*;
  import lz4d_tb_pkg::*;

  localparam int              HIST_DEPTH = 1 << DEF_WINDOW_BITS;
  localparam bit [31:0]       SIZE_TOP   = 32'd1 << DEF_SIZE_BITS;
  localparam bit [31:0]       LEN_MAX    = (32'd1 << (DEF_SIZE_BITS + 1)) - 1;
  localparam logic [CNT_W-1:0] TAKEN_MAX = CNT_W'(LEN_MAX);
  localparam int              TAIL_BYTES = 4;

  typedef enum logic [3:0] {
    DS_TOKEN, DS_LIT_EXT, DS_LITERAL, DS_OFF_LO, DS_OFF_HI,
    DS_MATCH_EXT, DS_MATCH, DS_DONE, DS_ERROR
  } dec_state_t;

  typedef struct {
    logic [BYTE_W-1:0] data;
    status_t           status;
    logic [CNT_W-1:0]  consumed;
  } dec_result_t;

  logic [BYTE_W-1:0] history [0:HIST_DEPTH-1];
  logic [OFF_W-1:0]  wr_ptr;
  bit [31:0]         out_count;
  bit [31:0]         run_left;
  logic [CNT_W-1:0]  in_count;
  dec_state_t        state;
  logic [NIB_W-1:0]  match_nib;
  logic [OFF_W-1:0]  match_dist;
  logic [CFG_W-1:0]  size_reg;
  dec_result_t       decoded_q[$];

  function automatic bit [31:0] block_size();
    bit [31:0] sz;
    sz = size_reg;
    if (sz < MIN_SIZE) sz = MIN_SIZE;
    if (sz > SIZE_TOP) sz = SIZE_TOP;
    return sz;
  endfunction

  function automatic void expect_result(logic [BYTE_W-1:0] d, status_t st);
    dec_result_t r;
    r.data     = d;
    r.status   = st;
    r.consumed = in_count;
    decoded_q.push_back(r);
  endfunction

  function automatic void flag_error();
    state = DS_ERROR;
    expect_result('0, ST_ERR);
  endfunction

  function automatic void grow_run(logic [BYTE_W-1:0] b);
    run_left = run_left + b;
    if (run_left > LEN_MAX) run_left = LEN_MAX;
  endfunction

  // A literal run ending within the last four bytes must be the final run
  // and must land exactly on the block size.
  function automatic void literal_len_known();
    bit [31:0] sz;
    bit [31:0] run_end;
    sz = block_size();
    run_end = out_count + run_left;
    if (run_end > sz - TAIL_BYTES) begin
      if (run_end != sz || run_left == 0) flag_error();
      else state = DS_LITERAL;
    end else begin
      state = (run_left != 0) ? DS_LITERAL : DS_OFF_LO;
    end
  endfunction

  function automatic void match_len_known();
    if (out_count + run_left > block_size()) flag_error();
    else state = DS_MATCH;
  endfunction

  function automatic void emit_byte(logic [BYTE_W-1:0] b, dec_state_t next);
    history[wr_ptr] = b;
    wr_ptr = wr_ptr + 1'b1;
    out_count = out_count + 1;
    if (run_left != 0) run_left = run_left - 1;
    if (run_left == 0) state = (out_count >= block_size()) ? DS_DONE : next;
    expect_result(b, ST_BYTE);
  endfunction

  function automatic void decode_item(logic req, logic [BYTE_W-1:0] b);
    if (state == DS_DONE) begin
      expect_result('0, ST_DONE);
      return;
    end
    if (state == DS_ERROR) begin
      expect_result('0, ST_ERR);
      return;
    end
    if (req == REQ_ADVANCE) begin
      if (state == DS_MATCH) emit_byte(history[wr_ptr - match_dist], DS_TOKEN);
      return;
    end
    // A byte offered while match bytes are still owed is dropped uncounted.
    if (state == DS_MATCH) return;
    if (in_count != TAKEN_MAX) in_count = in_count + 1'b1;
    case (state)
      DS_TOKEN: begin
        match_nib = b[3:0];
        run_left = b[7:4];
        if (b[7:4] == NIB_EXT) state = DS_LIT_EXT;
        else literal_len_known();
      end
      DS_LIT_EXT: begin
        grow_run(b);
        if (b != BYTE_EXT) literal_len_known();
      end
      DS_LITERAL: emit_byte(b, DS_OFF_LO);
      DS_OFF_LO: begin
        match_dist = {8'h00, b};
        state = DS_OFF_HI;
      end
      DS_OFF_HI: begin
        match_dist[15:8] = b;
        if (match_dist == 0 || match_dist > out_count) begin
          flag_error();
        end else begin
          run_left = match_nib + MIN_MATCH;
          if (match_nib == NIB_EXT) state = DS_MATCH_EXT;
          else match_len_known();
        end
      end
      DS_MATCH_EXT: begin
        grow_run(b);
        if (b != BYTE_EXT) match_len_known();
      end
      default: flag_error();
    endcase
  endfunction

  function automatic void compare_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      fail_count++;
    end
  endfunction

  function automatic void check_result();
    dec_result_t want;
    if (decoded_q.size() == 0) begin
      $error("result with nothing expected: out_byte 0x%0h status %0d bytes_consumed %0d",
             out_ch.out_byte, out_ch.status, out_ch.bytes_consumed);
      fail_count++;
      return;
    end
    want = decoded_q.pop_front();
    compare_field("out_byte", want.data, out_ch.out_byte);
    compare_field("status", want.status, out_ch.status);
    compare_field("bytes_consumed", want.consumed, out_ch.bytes_consumed);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr = '0;
      out_count = 0;
      run_left = 0;
      in_count = '0;
      state = DS_TOKEN;
      match_nib = '0;
      match_dist = '0;
      size_reg = RESET_SIZE;
      fail_count = 0;
      decoded_q.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) check_result();
      if (cfg_ch.valid && cfg_ch.ready) size_reg = cfg_ch.output_size;
      if (in_ch.valid && in_ch.ready) decode_item(in_ch.req_type, in_ch.in_byte);
    end
    pending = decoded_q.size();
  end

endmodule

[tb/sv/lz4_block_decoder_test.sv]
// Stimulus and verdict for the LZ4 block decoder: one long block, then its end.
`timescale 1ns / 1ps
module lz4_block_decoder_test;
  import lz4d_pkg::*;
  import lz4d_tb_pkg::*;

  // Cycles with no transfer on any channel before the run is abandoned.
  localparam int WATCHDOG_CYCLES = 2000;
  // Results pass through the result stage into the output register; the drain
  // lets header bytes still in flight settle.
  localparam int DRAIN_CYCLES = 4;
  localparam int DIST_MAX = (1 << OFF_W) - 1;
  localparam logic [CFG_W-1:0] SIZE_TOP = CFG_W'(1 << DEF_SIZE_BITS);

  logic clk;
  logic rst_n = 1'b0;

  lz4d_in_if  in_ch ();
  lz4d_out_if out_ch ();
  lz4d_cfg_if cfg_ch ();

  int fail_count;
  int pending;
  int send_idle_pct;
  int recv_idle_pct;
  int stream_bytes;  // decompressed bytes the generated stream defines so far
  int sent_items;
  int noise_items;   // requests the block is meant to drop
  int quiet_cycles;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  lz4_block_decoder dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  lz4_block_decoder_checker decode_monitor (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_ch     (cfg_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // The receiver stalls at random, at the rate of the current idling phase.
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Any transfer on any channel counts as progress.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("lz4_block_decoder_test: FAIL");
      $finish;
    end
  end

  // One input transfer, preceded by random idle cycles. Valid stays high
  // after the transfer so that back-to-back items never drop it.
  task automatic send_item(input logic req, input logic [BYTE_W-1:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.req_type <= req;
    in_ch.in_byte  <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent_items++;
  endtask

  task automatic send_noise(input logic req);
    send_item(req, BYTE_W'($urandom));
    noise_items++;
  endtask

  // Now and then a request that the block should drop: a byte while match
  // bytes are owed, or an advance while none are.
  task automatic maybe_noise(input bit in_match);
    if ($urandom_range(99) < 3) send_noise(in_match ? REQ_BYTE : REQ_ADVANCE);
  endtask

  // The 255-extension of a length: bytes of 255 until the rest is smaller.
  task automatic send_length_tail(input int rest);
    while (rest >= 255) begin
      send_item(REQ_BYTE, BYTE_EXT);
      rest -= 255;
    end
    send_item(REQ_BYTE, BYTE_W'(rest));
  endtask

  // One LZ4 sequence: token, literal length extension, literals and, when
  // there is a match, the offset, the match length extension and one advance
  // per match byte. Without a match the token's low nibble is random.
  task automatic send_sequence(input int lit_len, input bit has_match, input int distance,
                               input int match_len, input bit noisy);
    int lit_nib;
    int mat_nib;
    lit_nib = (lit_len >= 15) ? 15 : lit_len;
    if (has_match) mat_nib = (match_len - MIN_MATCH >= 15) ? 15 : match_len - MIN_MATCH;
    else mat_nib = $urandom_range(15);
    if (noisy) maybe_noise(1'b0);
    send_item(REQ_BYTE, {NIB_W'(lit_nib), NIB_W'(mat_nib)});
    if (lit_nib == 15) send_length_tail(lit_len - 15);
    repeat (lit_len) begin
      if (noisy) maybe_noise(1'b0);
      send_item(REQ_BYTE, BYTE_W'($urandom));
    end
    if (has_match) begin
      send_item(REQ_BYTE, BYTE_W'(distance));
      send_item(REQ_BYTE, BYTE_W'(distance >> 8));
      if (mat_nib == 15) send_length_tail(match_len - MIN_MATCH - 15);
      repeat (match_len) begin
        if (noisy) maybe_noise(1'b1);
        send_item(REQ_ADVANCE, BYTE_W'($urandom));
      end
    end
    stream_bytes += lit_len + (has_match ? match_len : 0);
  endtask

  function automatic int dist_reach(input int n);
    return (n > DIST_MAX) ? DIST_MAX : n;
  endfunction

  // A well-formed sequence of random shape. Most lengths fit in the token;
  // a few need an extension byte and a rare one runs through bytes of 255.
  // Short distances dominate so that overlapping copies are common.
  task automatic send_random_sequence();
    int lit_len;
    int match_len;
    int distance;
    int reach;
    int pick;
    pick = $urandom_range(59);
    if (pick == 0) lit_len = 270 + $urandom_range(300);
    else if (pick < 7) lit_len = $urandom_range(15, 40);
    else lit_len = $urandom_range(0, 14);
    if (stream_bytes + lit_len == 0) lit_len = 1;
    reach = dist_reach(stream_bytes + lit_len);
    if ($urandom_range(1)) distance = $urandom_range(1, (reach < 8) ? reach : 8);
    else distance = $urandom_range(1, reach);
    pick = $urandom_range(79);
    if (pick == 0) match_len = 274 + $urandom_range(20);
    else if (pick < 8) match_len = $urandom_range(19, 60);
    else match_len = $urandom_range(MIN_MATCH, 18);
    send_sequence(lit_len, 1'b1, distance, match_len, 1'b1);
  endtask

  // Lower valid, let the checker see the last transfer, wait for every
  // expected result and then for header bytes still in the pipeline.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // The size register is written only with the block idle.
  task automatic write_size(input logic [CFG_W-1:0] value);
    wait_idle();
    cfg_ch.valid       <= 1'b1;
    cfg_ch.output_size <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic run_phase(input int useful_target);
    while (sent_items - noise_items < useful_target) send_random_sequence();
  endtask

  // Short directed opening under the reset value of the size register.
  task automatic run_directed();
    // An advance with nothing owed is dropped.
    send_noise(REQ_ADVANCE);
    // Literals at both byte extremes, then a match at distance one that
    // repeats the last byte four times; a stray byte in the middle of the
    // match must be dropped.
    send_item(REQ_BYTE, 8'h20);
    send_item(REQ_BYTE, 8'h00);
    send_item(REQ_BYTE, 8'hFF);
    send_item(REQ_BYTE, 8'h01);
    send_item(REQ_BYTE, 8'h00);
    send_item(REQ_ADVANCE, 8'h00);
    send_item(REQ_ADVANCE, 8'hFF);
    send_noise(REQ_BYTE);
    send_item(REQ_ADVANCE, 8'h00);
    send_item(REQ_ADVANCE, 8'h00);
    // One literal and a seven-byte match at distance three, which copies
    // bytes it has written itself.
    send_item(REQ_BYTE, 8'h13);
    send_item(REQ_BYTE, 8'h5A);
    send_item(REQ_BYTE, 8'h03);
    send_item(REQ_BYTE, 8'h00);
    repeat (7) send_item(REQ_ADVANCE, BYTE_W'($urandom));
    stream_bytes = 14;
  endtask

  // End the block in one of its ways, chosen by the seed: clean completion
  // by the final literal run or by a match, or one of the error cases.
  task automatic end_block();
    int lit_len;
    int match_len;
    int distance;
    int short_by;
    case ($urandom_range(6))
      0: begin
        // Final literal run landing exactly on the block size.
        lit_len = $urandom_range(1, 40);
        write_size(CFG_W'(stream_bytes + lit_len));
        send_sequence(lit_len, 1'b0, 0, 0, 1'b0);
      end
      1: begin
        // A match that ends exactly on the block size completes it.
        lit_len = $urandom_range(0, 10);
        match_len = $urandom_range(MIN_MATCH, 40);
        distance = $urandom_range(1, dist_reach(stream_bytes + lit_len));
        write_size(CFG_W'(stream_bytes + lit_len + match_len));
        send_sequence(lit_len, 1'b1, distance, match_len, 1'b0);
      end
      2: begin
        // A literal run ending in the last four bytes but not on the size,
        // or an empty literal run that far in.
        short_by = $urandom_range(1, 3);
        if ($urandom_range(1)) begin
          lit_len = $urandom_range(1, 20);
          write_size(CFG_W'(stream_bytes + lit_len + short_by));
          send_sequence(lit_len, 1'b0, 0, 0, 1'b0);
        end else begin
          write_size(CFG_W'(stream_bytes + short_by));
          send_sequence(0, 1'b0, 0, 0, 1'b0);
        end
      end
      3: begin
        // A match running past the block size.
        lit_len = $urandom_range(0, 10);
        match_len = $urandom_range(MIN_MATCH + 1, 40);
        short_by = $urandom_range(1, match_len - MIN_MATCH);
        distance = $urandom_range(1, dist_reach(stream_bytes + lit_len));
        write_size(CFG_W'(stream_bytes + lit_len + match_len - short_by));
        send_sequence(lit_len, 1'b1, distance, match_len, 1'b0);
      end
      4: begin
        // Distance zero, or a distance reaching before the first byte.
        lit_len = $urandom_range(0, 10);
        if ($urandom_range(1)) distance = 0;
        else distance = $urandom_range(stream_bytes + lit_len + 1, DIST_MAX);
        send_sequence(lit_len, 1'b1, distance, $urandom_range(MIN_MATCH, 20), 1'b0);
      end
      5: begin
        // A size below the minimum acts as four, far behind the output.
        write_size(CFG_W'($urandom_range(0, MIN_SIZE - 1)));
        send_sequence($urandom_range(0, 10), 1'b1, 1, MIN_MATCH, 1'b0);
      end
      default: begin
        // A literal length carried by extension bytes well past the block size.
        write_size(CFG_W'(stream_bytes + 200));
        send_item(REQ_BYTE, {NIB_EXT, NIB_W'($urandom)});
        repeat (2) send_item(REQ_BYTE, BYTE_EXT);
        send_item(REQ_BYTE, BYTE_W'($urandom_range(0, 254)));
      end
    endcase
    // Once the block has ended, every request reports that end and takes
    // nothing.
    repeat (12) send_item(logic'($urandom_range(1)), BYTE_W'($urandom));
  endtask

  initial begin
    in_ch.valid        = 1'b0;
    in_ch.req_type     = REQ_BYTE;
    in_ch.in_byte      = '0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.output_size = RESET_SIZE;
    sent_items         = 0;
    noise_items        = 0;
    stream_bytes       = 0;
    // Sender idles little and the receiver much in the first phase.
    send_idle_pct      = 12;
    recv_idle_pct      = 62;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();
    // Largest size the block honours, then the all-ones value that it clamps.
    write_size(SIZE_TOP);
    run_phase(660);
    write_size('1);
    send_idle_pct = 62;
    recv_idle_pct = 12;
    run_phase(1300);
    write_size(CFG_W'($urandom_range(stream_bytes + 4000, 1 << DEF_SIZE_BITS)));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_phase(1860);
    end_block();
    wait_idle();

    if (fail_count == 0 && pending == 0) begin
      $display("lz4_block_decoder_test: PASS");
    end else begin
      $display("lz4_block_decoder_test: FAIL");
    end
    $finish;
  end

endmodule
